>>> design/stq_pkg.sv
package stq_pkg;

    localparam int TIME_W         = 32;
    localparam int SLOT_W         = 4;
    localparam int DELAY_W        = 16;
    localparam int REQ_W          = 2;
    localparam int NUM_TIMERS_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_ADJUST = 2'd1,
        REQ_TICK   = 2'd2
    } req_t;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic              live;
        logic [TIME_W-1:0] expiry;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] op_time;
        logic [SLOT_W-1:0] op_id;
    } cell_cmd_t;

endpackage

>>> design/stq_cell.sv
module stq_cell
    import stq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    prev_ent,
    input  logic      prev_keep,
    input  entry_t    next_ent,
    input  logic      seen_in,
    output logic      seen_out,
    output logic      keep,
    output entry_t    ent
);

    logic              live_reg;
    logic              live_next;
    logic [TIME_W-1:0] expiry_reg;
    logic [TIME_W-1:0] expiry_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              match;

    assign ent.live   = live_reg;
    assign ent.expiry = expiry_reg;
    assign ent.slot   = slot_reg;

    // keep: live and not later than the command time (also "due" on a tick)
    assign keep     = live_reg && (expiry_reg <= cmd.op_time);
    assign match    = live_reg && (slot_reg == cmd.op_id);
    assign seen_out = seen_in || match;

    always_comb
    begin
        live_next   = live_reg;
        expiry_next = expiry_reg;
        slot_next   = slot_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        live_next   = 1'b1;
                        expiry_next = cmd.op_time;
                        slot_next   = cmd.op_id;
                    end
                    else
                    begin
                        live_next   = prev_ent.live;
                        expiry_next = prev_ent.expiry;
                        slot_next   = prev_ent.slot;
                    end
                end
            end
            CELL_REMOVE:
            begin
                // matched here or upstream: close the gap from the right
                if (seen_out)
                begin
                    live_next   = next_ent.live;
                    expiry_next = next_ent.expiry;
                    slot_next   = next_ent.slot;
                end
            end
            CELL_POP:
            begin
                live_next   = next_ent.live;
                expiry_next = next_ent.expiry;
                slot_next   = next_ent.slot;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b0;
        else
            live_reg <= live_next;
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        slot_reg   <= slot_next;
    end

endmodule

>>> design/sorted_timer_expiry_queue.sv
// channel | handshake           | fields
// --------+---------------------+-----------------------------------------------------
// in      | in_valid / in_stall | req_type, timer_id, expire_time, delay, current_time
// out     | out_valid/out_stall | expired_id, last
//
// Add runs one insert pass (skipped if the id is present or the queue is full); adjust runs a
// remove pass and, if the id was found, an insert pass; tick pops each expired id in turn.
// Each cell compares its expiry against the broadcast time, so a pass covers all cells at once.
// Reset clears the live bits of all cells; expiry and slot storage is not reset.
// A stalled output holds the tick walk; adds and adjusts run while a result waits.
module sorted_timer_expiry_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [SLOT_W-1:0]  timer_id,
    input  logic [TIME_W-1:0]  expire_time,
    input  logic [DELAY_W-1:0] delay,
    input  logic [TIME_W-1:0]  current_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SLOT_W-1:0]  expired_id,
    output logic               last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_INSERT,
        S_TICK
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] op_time_reg;
    logic [TIME_W-1:0] op_time_next;
    logic [SLOT_W-1:0] op_id_reg;
    logic [SLOT_W-1:0] op_id_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SLOT_W-1:0] expired_id_reg;
    logic [SLOT_W-1:0] expired_id_next;
    logic              last_reg;
    logic              last_next;

    cell_op_t          cell_op;
    cell_cmd_t         cmd;
    entry_t            ent [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] keep_vec;
    logic [NUM_TIMERS-1:0] live_vec;
    logic [NUM_TIMERS:0]   seen;
    logic [TIME_W:0]       adj_sum;
    logic [TIME_W-1:0]     adj_time;
    logic                  hit;
    logic                  full;
    logic                  out_free;

    assign seen[0] = 1'b0;
    assign hit     = seen[NUM_TIMERS];
    assign full    = live_vec[NUM_TIMERS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            entry_t prev_ent;
            entry_t next_ent;
            logic   prev_keep;

            if (gi == 0)
            begin : g_head
                assign prev_ent  = '0;
                assign prev_keep = 1'b1;
            end
            else
            begin : g_body
                assign prev_ent  = ent[gi-1];
                assign prev_keep = keep_vec[gi-1];
            end

            if (gi == NUM_TIMERS - 1)
            begin : g_tail
                assign next_ent = '0;
            end
            else
            begin : g_link
                assign next_ent = ent[gi+1];
            end

            stq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_ent  (prev_ent),
                .prev_keep (prev_keep),
                .next_ent  (next_ent),
                .seen_in   (seen[gi]),
                .seen_out  (seen[gi+1]),
                .keep      (keep_vec[gi]),
                .ent       (ent[gi])
            );

            assign live_vec[gi] = ent[gi].live;
        end
    endgenerate

    // adjust time saturates at the top of the range
    assign adj_sum  = {1'b0, current_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
    assign adj_time = adj_sum[TIME_W] ? {TIME_W{1'b1}} : adj_sum[TIME_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign cmd      = {cell_op, op_time_reg, op_id_reg};

    always_comb
    begin
        state_next      = state_reg;
        op_time_next    = op_time_reg;
        op_id_next      = op_id_reg;
        out_valid_next  = out_valid_reg && out_stall;
        expired_id_next = expired_id_reg;
        last_next       = last_reg;
        cell_op         = CELL_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_id_next = timer_id;
                    case (req_t'(req_type))
                        REQ_ADD:
                        begin
                            op_time_next = expire_time;
                            state_next   = S_ADD;
                        end
                        REQ_ADJUST:
                        begin
                            op_time_next = adj_time;
                            state_next   = S_REMOVE;
                        end
                        REQ_TICK:
                        begin
                            op_time_next = current_time;
                            state_next   = S_TICK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (!hit && !full)
                    cell_op = CELL_INSERT;
                state_next = S_IDLE;
            end
            S_REMOVE:
            begin
                if (hit)
                begin
                    cell_op    = CELL_REMOVE;
                    state_next = S_INSERT;
                end
                else
                    state_next = S_IDLE;
            end
            S_INSERT:
            begin
                cell_op    = CELL_INSERT;
                state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    if (keep_vec[0])
                    begin
                        cell_op         = CELL_POP;
                        out_valid_next  = 1'b1;
                        expired_id_next = ent[0].slot;
                        last_next       = !keep_vec[1];
                        if (!keep_vec[1])
                            state_next = S_IDLE;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_time_reg    <= '0;
            op_id_reg      <= '0;
            out_valid_reg  <= 1'b0;
            expired_id_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_time_reg    <= op_time_next;
            op_id_reg      <= op_id_next;
            out_valid_reg  <= out_valid_next;
            expired_id_reg <= expired_id_next;
            last_reg       <= last_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign expired_id = expired_id_reg;
    assign last       = last_reg;

    // ordering check between neighboring live cells
    logic [NUM_TIMERS-2:0] order_bad;
    generate
        for (gi = 0; gi < NUM_TIMERS - 1; gi++)
        begin : g_order
            assign order_bad[gi] = ent[gi+1].live && (ent[gi].expiry > ent[gi+1].expiry);
        end
    endgenerate

    a_live_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((live_vec >> 1) & ~live_vec) == '0)
        else $error("live cells do not form an unbroken run from the head");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        order_bad == '0)
        else $error("live cells out of expiry order");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> state_reg == S_TICK)
        else $error("non-final expired id shown but tick walk ended");

    a_pop_only_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == CELL_POP |-> keep_vec[0] && state_reg == S_TICK)
        else $error("head popped without being due");

endmodule
